// ===== rtl/ajr_pkg.sv =====
`default_nettype none

package ajr_pkg;

  // Operation codes carried in the op field
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_FLUSH = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_CHANNELS = 2'd0,
    REG_CAPACITY = 2'd1,
    REG_TARGET   = 2'd2
  } reg_idx_e;

  localparam int unsigned CfgWidth = 12;

  // Register values after reset
  localparam logic [3:0]  ChannelsReset = 4'd2;
  localparam logic [11:0] CapacityReset = 12'd2048;
  localparam logic [11:0] TargetReset   = 12'd0;

  // One input item
  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] sample_in;
    logic        burst_start;
    logic        burst_end;
  } in_item_t;

  // One result item
  typedef struct packed {
    logic [31:0] sample_out;
    logic        accepted;
    logic [11:0] level_frames;
    logic        priming_flag;
    logic [31:0] frames_written;
    logic [31:0] frames_read;
    logic [31:0] underrun_count;
    logic [31:0] overrun_count;
    logic [31:0] resync_count;
  } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/ajr_stream_if.sv =====
`default_nettype none

interface ajr_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/ajr_ram.sv =====
`default_nettype none

module ajr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16384
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port, and read port with registered data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/audio_jitter_ring.sv =====
// Channel   Dir  Handshake     Payload
// in_i      in   valid/ready   op, sample_in, burst_start, burst_end
// out_o     out  valid/ready   sample_out, accepted, level, priming, five counters
// cfg       in   cfg_we_i      cfg_idx_i selects register, cfg_wdata_i holds value
//
// One item a cycle while the output stage can take it; each result appears in the cycle after its item is taken.
// The ring read is a single registered port of the sample RAM, which sets the latency.
// A stalled result holds in the output stage; a new item is taken when that stage
// empties or is taken in the same cycle.
// Reset clears all pointers and counters; the sample RAM needs no clearing pass.
`default_nettype none

module audio_jitter_ring #(
  parameter int unsigned MAX_FRAMES   = 2048,
  parameter int unsigned MAX_CHANNELS = 8,
  parameter int unsigned SAMPLE_BITS  = 32
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  ajr_stream_if.sink                          in_i,
  ajr_stream_if.source                        out_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [1:0]                     cfg_idx_i,
  input  wire logic [ajr_pkg::CfgWidth-1:0]   cfg_wdata_i
);

  localparam int unsigned FW    = $clog2(MAX_FRAMES + 1);
  localparam int unsigned PW    = $clog2(MAX_FRAMES);
  localparam int unsigned CW    = $clog2(MAX_CHANNELS + 1);
  localparam int unsigned XW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned DEPTH = MAX_FRAMES * MAX_CHANNELS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CapRst = (2048 > MAX_FRAMES) ? MAX_FRAMES : 2048;
  localparam int unsigned ChRst  = (2 > MAX_CHANNELS) ? MAX_CHANNELS : 2;

  // Configuration registers
  logic [3:0]  chan_cfg_q;
  logic [11:0] cap_cfg_q;
  logic [11:0] tgt_cfg_q;

  // Ring state
  logic [FW-1:0] cap_live_q, cap_live_d;
  logic [CW-1:0] ch_live_q, ch_live_d;
  logic [PW-1:0] wpos_q, wpos_d, rpos_q, rpos_d;
  logic [FW-1:0] lvl_q, lvl_d, ravail_q, ravail_d;
  logic          priming_q, priming_d;
  logic [XW-1:0] wchan_q, wchan_d, rchan_q, rchan_d;
  logic          keep_q, keep_d, dropped_q, dropped_d, zmode_q, zmode_d;
  logic          rshort_q, rshort_d, from_ring_q, from_ring_d;
  logic [31:0]   wr_cnt_q, wr_cnt_d, rd_cnt_q, rd_cnt_d, und_cnt_q, und_cnt_d;
  logic [31:0]   ovr_cnt_q, ovr_cnt_d, res_cnt_q, res_cnt_d;

  // Output stage
  logic s1_valid_q, s1_acc_q, s1_ring_q;
  logic acc_d, ring_rd_d;

  // RAM port
  logic                   ram_we, ram_re;
  logic [AW-1:0]          ram_waddr, ram_raddr;
  logic [SAMPLE_BITS-1:0] ram_rdata;

  logic          fire;
  logic [FW-1:0] half, eff_t, lvl_up;
  logic [FW:0]   skip_sum;
  logic [FW-1:0] wpos_inc, rpos_inc;
  logic [PW-1:0] rpos_cur;
  logic [XW-1:0] wc, rc;
  logic          wlast, rlast;
  logic [FW-1:0] cap_new;
  logic [CW-1:0] ch_new;

  assign fire       = in_i.valid && in_i.ready;
  assign in_i.ready = !s1_valid_q || out_o.ready;

  // Clamped target and the values a flush latches
  always_comb begin
    half  = cap_live_q >> 1;
    eff_t = (32'(tgt_cfg_q) > 32'(half)) ? half : FW'(tgt_cfg_q);
    if (cap_cfg_q == '0) begin
      cap_new = FW'(1);
    end else if (32'(cap_cfg_q) > 32'(MAX_FRAMES)) begin
      cap_new = FW'(MAX_FRAMES);
    end else begin
      cap_new = FW'(cap_cfg_q);
    end
    if (chan_cfg_q == '0) begin
      ch_new = CW'(1);
    end else if (32'(chan_cfg_q) > 32'(MAX_CHANNELS)) begin
      ch_new = CW'(MAX_CHANNELS);
    end else begin
      ch_new = CW'(chan_cfg_q);
    end
  end

  // Next state for one item
  always_comb begin
    cap_live_d  = cap_live_q;
    ch_live_d   = ch_live_q;
    wpos_d      = wpos_q;
    rpos_d      = rpos_q;
    lvl_d       = lvl_q;
    ravail_d    = ravail_q;
    priming_d   = priming_q;
    wchan_d     = wchan_q;
    rchan_d     = rchan_q;
    keep_d      = keep_q;
    dropped_d   = dropped_q;
    zmode_d     = zmode_q;
    rshort_d    = rshort_q;
    from_ring_d = from_ring_q;
    wr_cnt_d    = wr_cnt_q;
    rd_cnt_d    = rd_cnt_q;
    und_cnt_d   = und_cnt_q;
    ovr_cnt_d   = ovr_cnt_q;
    res_cnt_d   = res_cnt_q;
    acc_d       = 1'b0;
    ring_rd_d   = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    wc          = in_i.data.burst_start ? '0 : wchan_q;
    rc          = in_i.data.burst_start ? '0 : rchan_q;
    wlast       = ((CW + 1)'(wc) + (CW + 1)'(1)) >= (CW + 1)'(ch_live_q);
    rlast       = ((CW + 1)'(rc) + (CW + 1)'(1)) >= (CW + 1)'(ch_live_q);
    lvl_up      = lvl_q + FW'(1);
    wpos_inc    = FW'(wpos_q) + FW'(1);
    rpos_cur    = rpos_q;
    rpos_inc    = '0;
    skip_sum    = '0;

    unique case (in_i.data.op)
      ajr_pkg::OP_WRITE: begin
        // Decide at the frame start whether the frame fits
        if (in_i.data.burst_start) begin
          dropped_d = 1'b0;
        end
        if (wc == '0) begin
          keep_d = lvl_q < cap_live_q;
          if (!(lvl_q < cap_live_q)) begin
            dropped_d = 1'b1;
          end
        end
        if (keep_d) begin
          ram_we = 1'b1;
          acc_d  = 1'b1;
        end
        // Commit the frame on its last sample
        if (wlast) begin
          if (keep_d && lvl_q < cap_live_q) begin
            wpos_d   = (wpos_inc == cap_live_q) ? '0 : PW'(wpos_inc);
            lvl_d    = lvl_up;
            wr_cnt_d = wr_cnt_q + 32'd1;
            if (priming_q && lvl_up >= eff_t) begin
              priming_d = 1'b0;
            end
          end
          wchan_d = '0;
        end else begin
          wchan_d = XW'(wc + XW'(1));
        end
        if (in_i.data.burst_end) begin
          wchan_d = '0;
          if (dropped_d) begin
            ovr_cnt_d = ovr_cnt_q + 32'd1;
          end
          dropped_d = 1'b0;
        end
      end
      ajr_pkg::OP_READ: begin
        // Burst start: pick mode, trim drift, snapshot the level
        if (in_i.data.burst_start) begin
          from_ring_d = 1'b0;
          rshort_d    = 1'b0;
          if (priming_q) begin
            zmode_d = 1'b1;
          end else begin
            zmode_d = 1'b0;
            if (eff_t != '0 && 32'(lvl_q) > (32'(eff_t) << 1)) begin
              skip_sum  = (FW + 1)'(rpos_q) + (FW + 1)'(lvl_q - eff_t);
              rpos_cur  = (skip_sum >= (FW + 1)'(cap_live_q)) ?
                          PW'(skip_sum - (FW + 1)'(cap_live_q)) : PW'(skip_sum);
              lvl_d     = eff_t;
              res_cnt_d = res_cnt_q + 32'd1;
            end
            ravail_d = lvl_d;
          end
        end
        // Frame start: take from the ring or fill with zeros
        if (rc == '0) begin
          if (zmode_d) begin
            from_ring_d = 1'b0;
          end else if (ravail_d != '0) begin
            from_ring_d = 1'b1;
            ravail_d    = ravail_d - FW'(1);
          end else begin
            from_ring_d = 1'b0;
            rshort_d    = 1'b1;
          end
        end
        if (from_ring_d) begin
          ram_re    = 1'b1;
          acc_d     = 1'b1;
          ring_rd_d = 1'b1;
        end
        // Consume the frame on its last sample
        rpos_inc = FW'(rpos_cur) + FW'(1);
        rpos_d   = rpos_cur;
        if (rlast) begin
          if (from_ring_d && lvl_d != '0) begin
            rpos_d   = (rpos_inc == cap_live_q) ? '0 : PW'(rpos_inc);
            lvl_d    = lvl_d - FW'(1);
            rd_cnt_d = rd_cnt_q + 32'd1;
          end
          from_ring_d = 1'b0;
          rchan_d     = '0;
        end else begin
          rchan_d = XW'(rc + XW'(1));
        end
        if (in_i.data.burst_end) begin
          rchan_d     = '0;
          from_ring_d = 1'b0;
          if (rshort_d && !zmode_d) begin
            und_cnt_d = und_cnt_q + 32'd1;
            priming_d = 1'b1;
          end
          rshort_d = 1'b0;
        end
      end
      ajr_pkg::OP_FLUSH: begin
        // Clear pointers and latch geometry; counters stay
        cap_live_d  = cap_new;
        ch_live_d   = ch_new;
        wpos_d      = '0;
        rpos_d      = '0;
        lvl_d       = '0;
        priming_d   = 1'b1;
        wchan_d     = '0;
        rchan_d     = '0;
        keep_d      = 1'b0;
        dropped_d   = 1'b0;
        zmode_d     = 1'b0;
        rshort_d    = 1'b0;
        from_ring_d = 1'b0;
        ravail_d    = '0;
      end
      default: begin
      end
    endcase

    ram_we    = ram_we && fire;
    ram_re    = ram_re && fire;
    ram_waddr = AW'(wpos_q) * AW'(MAX_CHANNELS) + AW'(wc);
    ram_raddr = AW'(rpos_cur) * AW'(MAX_CHANNELS) + AW'(rc);
  end

  // Hold configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_cfg_q <= ajr_pkg::ChannelsReset;
      cap_cfg_q  <= ajr_pkg::CapacityReset;
      tgt_cfg_q  <= ajr_pkg::TargetReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ajr_pkg::REG_CHANNELS: chan_cfg_q <= cfg_wdata_i[3:0];
        ajr_pkg::REG_CAPACITY: cap_cfg_q  <= cfg_wdata_i;
        ajr_pkg::REG_TARGET:   tgt_cfg_q  <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Advance ring state on each transfer in
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_live_q  <= FW'(CapRst);
      ch_live_q   <= CW'(ChRst);
      wpos_q      <= '0;
      rpos_q      <= '0;
      lvl_q       <= '0;
      ravail_q    <= '0;
      priming_q   <= 1'b1;
      wchan_q     <= '0;
      rchan_q     <= '0;
      keep_q      <= 1'b0;
      dropped_q   <= 1'b0;
      zmode_q     <= 1'b0;
      rshort_q    <= 1'b0;
      from_ring_q <= 1'b0;
      wr_cnt_q    <= '0;
      rd_cnt_q    <= '0;
      und_cnt_q   <= '0;
      ovr_cnt_q   <= '0;
      res_cnt_q   <= '0;
    end else if (fire) begin
      cap_live_q  <= cap_live_d;
      ch_live_q   <= ch_live_d;
      wpos_q      <= wpos_d;
      rpos_q      <= rpos_d;
      lvl_q       <= lvl_d;
      ravail_q    <= ravail_d;
      priming_q   <= priming_d;
      wchan_q     <= wchan_d;
      rchan_q     <= rchan_d;
      keep_q      <= keep_d;
      dropped_q   <= dropped_d;
      zmode_q     <= zmode_d;
      rshort_q    <= rshort_d;
      from_ring_q <= from_ring_d;
      wr_cnt_q    <= wr_cnt_d;
      rd_cnt_q    <= rd_cnt_d;
      und_cnt_q   <= und_cnt_d;
      ovr_cnt_q   <= ovr_cnt_d;
      res_cnt_q   <= res_cnt_d;
    end
  end

  // Output stage: load on transfer in, drop on transfer out
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_acc_q   <= 1'b0;
      s1_ring_q  <= 1'b0;
    end else if (fire) begin
      s1_valid_q <= 1'b1;
      s1_acc_q   <= acc_d;
      s1_ring_q  <= ring_rd_d;
    end else if (out_o.ready) begin
      s1_valid_q <= 1'b0;
    end
  end

  ajr_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_i.data.sample_in[SAMPLE_BITS-1:0]),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Status comes straight from the state, which holds while a result waits
  assign out_o.valid                = s1_valid_q;
  assign out_o.data.sample_out      = s1_ring_q ? 32'(ram_rdata) : 32'd0;
  assign out_o.data.accepted        = s1_acc_q;
  assign out_o.data.level_frames    = 12'(lvl_q);
  assign out_o.data.priming_flag    = priming_q;
  assign out_o.data.frames_written  = wr_cnt_q;
  assign out_o.data.frames_read     = rd_cnt_q;
  assign out_o.data.underrun_count  = und_cnt_q;
  assign out_o.data.overrun_count   = ovr_cnt_q;
  assign out_o.data.resync_count    = res_cnt_q;

  // Checks
  a_level_in_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lvl_q <= cap_live_q) else $error("level above capacity");

  a_pos_in_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    FW'(wpos_q) < cap_live_q && FW'(rpos_q) < cap_live_q)
    else $error("ring pointer beyond capacity");

  a_chan_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CW + 1)'(wchan_q) < (CW + 1)'(ch_live_q) && (CW + 1)'(rchan_q) < (CW + 1)'(ch_live_q))
    else $error("channel index beyond frame");

  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && in_i.data.op == ajr_pkg::OP_FLUSH |=> lvl_q == '0 && priming_q)
    else $error("flush did not clear the ring");

  a_write_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> $stable(wr_cnt_q) && $stable(lvl_q))
    else $error("state moved without a transfer");

endmodule

`default_nettype wire
